// ===== hw/rtl/bmmd_pkg.sv =====
// Package for the banked memory map decoder.
// Holds the access codes, address map constants, memory sizes and the control structs.
// Depends on nothing; bmmd_clear, bmmd_decode and the top level use it.
package bmmd_pkg;

   localparam int RamDepth   = 65536;
   localparam int ColorDepth = 1024;
   localparam int RomDepth   = 20480;
   localparam int RamAw      = $clog2(RamDepth);
   localparam int ColorAw    = $clog2(ColorDepth);
   localparam int RomAw      = $clog2(RomDepth);

   localparam logic [15:0] BasicBase  = 16'hA000;
   localparam logic [15:0] OpenBase   = 16'hC000;
   localparam logic [15:0] IoBase     = 16'hD000;
   localparam logic [15:0] ColorBase  = 16'hD800;
   localparam logic [15:0] KernalBase = 16'hE000;
   localparam logic [7:0]  ColorSet   = 8'hF0;
   localparam logic [7:0]  Loc0Reset  = 8'hEF;
   localparam logic [7:0]  Loc1Reset  = 8'h07;
   localparam logic [2:0]  BankReset  = 3'd7;
   localparam logic [15:0] BankLoc    = 16'h0001;

   // The three ROM images share one memory.
   localparam logic [RomAw-1:0] RomBasicOff  = RomAw'(16'h0000);
   localparam logic [RomAw-1:0] RomKernalOff = RomAw'(16'h2000);
   localparam logic [RomAw-1:0] RomCharOff   = RomAw'(16'h4000);

   typedef enum logic [1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_LOAD   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SEL_ZERO  = 2'd0,
      SEL_RAM   = 2'd1,
      SEL_ROM   = 2'd2,
      SEL_COLOR = 2'd3
   } sel_type;

   typedef struct packed {
      logic               ram_we;
      logic               ram_re;
      logic [RamAw-1:0]   ram_addr;
      logic [7:0]         ram_wdata;
      logic               col_we;
      logic               col_re;
      logic [ColorAw-1:0] col_addr;
      logic [3:0]         col_wdata;
      logic               rom_we;
      logic               rom_re;
      logic [RomAw-1:0]   rom_addr;
      logic [7:0]         rom_wdata;
      logic               bank_we;
      logic [2:0]         bank_wdata;
      sel_type            sel;
   } access_type;

   typedef struct packed {
      logic             active;
      logic [RamAw-1:0] addr;
      logic [7:0]       wdata;
   } clear_type;

endpackage

// ===== hw/rtl/bmmd_if.sv =====
// Handshake channels of the banked memory map decoder: request and response.
// Depends on nothing; the top level takes one instance of each.
interface bmmd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, output mode, output address, output write_data, input ready);
   modport sink (input valid, input mode, input address, input write_data, output ready);
endinterface

interface bmmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink (input valid, input read_data, output ready);
endinterface

// ===== hw/rtl/bmmd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; the top level uses it for RAM, color nybbles and ROM images.
module bmmd_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/bmmd_clear.sv =====
// Clearing sequencer: after reset it sweeps the RAM once, one location a cycle.
// Depends on bmmd_pkg; the top level muxes its writes onto the memory ports.
module bmmd_clear (
   input  logic               clock,
   input  logic               reset,
   output bmmd_pkg::clear_type clr
);

   logic [bmmd_pkg::RamAw:0] count_ff;
   logic [bmmd_pkg::RamAw:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (!count_ff[bmmd_pkg::RamAw]) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      clr.active = !count_ff[bmmd_pkg::RamAw];
      clr.addr   = count_ff[bmmd_pkg::RamAw-1:0];
      case (count_ff[bmmd_pkg::RamAw-1:0])
         bmmd_pkg::RamAw'(0): clr.wdata = bmmd_pkg::Loc0Reset;
         bmmd_pkg::RamAw'(1): clr.wdata = bmmd_pkg::Loc1Reset;
         default:             clr.wdata = 8'h00;
      endcase
   end

endmodule

// ===== hw/rtl/bmmd_decode.sv =====
// Address decoder: maps one request and the bank bits onto memory accesses.
// Depends on bmmd_pkg; produces the access struct that the top level applies.
module bmmd_decode (
   input  logic [1:0]           mode,
   input  logic [15:0]          address,
   input  logic [7:0]           write_data,
   input  logic [2:0]           bank,
   output bmmd_pkg::access_type acc
);

   logic in_color;
   logic below_io;
   logic is_io;
   logic in_basic;
   logic is_kernal;

   assign in_color  = address[15:10] == bmmd_pkg::ColorBase[15:10];
   assign below_io  = address < bmmd_pkg::IoBase;
   assign is_io     = !below_io && address < bmmd_pkg::KernalBase;
   assign in_basic  = address >= bmmd_pkg::BasicBase && address < bmmd_pkg::OpenBase;
   assign is_kernal = address >= bmmd_pkg::KernalBase;

   always_comb begin
      acc            = '0;
      acc.sel        = bmmd_pkg::SEL_ZERO;
      acc.ram_addr   = address;
      acc.ram_wdata  = write_data;
      acc.col_addr   = address[bmmd_pkg::ColorAw-1:0];
      acc.col_wdata  = write_data[3:0];
      acc.rom_wdata  = write_data;
      acc.bank_wdata = write_data[2:0];
      acc.rom_addr   = bmmd_pkg::RomBasicOff + bmmd_pkg::RomAw'(address[12:0]);
      if (is_kernal) begin
         acc.rom_addr = bmmd_pkg::RomKernalOff + bmmd_pkg::RomAw'(address[12:0]);
      end else if (is_io) begin
         acc.rom_addr = bmmd_pkg::RomCharOff + bmmd_pkg::RomAw'(address[11:0]);
      end
      case (bmmd_pkg::mode_type'(mode))
         bmmd_pkg::MODE_READ: begin
            if (in_basic) begin
               if (bank[1:0] == 2'b11) begin
                  acc.sel = bmmd_pkg::SEL_ROM;
               end else begin
                  acc.sel = bmmd_pkg::SEL_RAM;
               end
            end else if (is_kernal) begin
               if (bank[1]) begin
                  acc.sel = bmmd_pkg::SEL_ROM;
               end else begin
                  acc.sel = bmmd_pkg::SEL_RAM;
               end
            end else if (is_io) begin
               if (bank[1:0] == 2'b00) begin
                  acc.sel = bmmd_pkg::SEL_RAM;
               end else if (!bank[2]) begin
                  acc.sel = bmmd_pkg::SEL_ROM;
               end else if (in_color) begin
                  acc.sel = bmmd_pkg::SEL_COLOR;
               end
            end else begin
               acc.sel = bmmd_pkg::SEL_RAM;
            end
            acc.ram_re = acc.sel == bmmd_pkg::SEL_RAM;
            acc.rom_re = acc.sel == bmmd_pkg::SEL_ROM;
            acc.col_re = acc.sel == bmmd_pkg::SEL_COLOR;
         end
         bmmd_pkg::MODE_WRITE: begin
            if (!is_io || bank == 3'd0) begin
               acc.ram_we  = 1'b1;
               acc.bank_we = address == bmmd_pkg::BankLoc;
            end else if (in_color) begin
               acc.col_we = 1'b1;
            end
         end
         bmmd_pkg::MODE_LOAD: begin
            acc.rom_we = in_basic || is_io || is_kernal;
         end
         default: begin
            acc.sel = bmmd_pkg::SEL_ZERO;
         end
      endcase
   end

endmodule

// ===== hw/rtl/banked_memory_map_decoder_top.sv =====
// Top level of the banked memory map decoder: memories, read stage and response register.
// Depends on bmmd_pkg, bmmd_if, bmmd_ram, bmmd_clear and bmmd_decode.
// A response passes the memory read register and then the response register.
// Throughput: one request per cycle, set by the single read port of each memory, while responses are not stalled.
// Reset: synchronous; afterwards a clearing pass sweeps all 65536 RAM locations and the
// color store, and no request is accepted until it ends. The ROM images start undefined.
module banked_memory_map_decoder_top (
   input logic         clock,
   input logic         reset,
   bmmd_req_if.sink    req_chan,
   bmmd_rsp_if.source  rsp_chan
);

   bmmd_pkg::clear_type  clr;
   bmmd_pkg::access_type acc;

   logic [2:0]        bank_ff;
   logic [2:0]        bank_in;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   bmmd_pkg::sel_type s1_sel_ff;
   bmmd_pkg::sel_type s1_sel_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [7:0]        out_data_ff;
   logic [7:0]        out_data_in;

   logic       out_free;
   logic       req_ready;
   logic       fire;
   logic       ram_we;
   logic [bmmd_pkg::RamAw-1:0]   ram_waddr;
   logic [7:0]                   ram_wdata;
   logic       col_we;
   logic [bmmd_pkg::ColorAw-1:0] col_waddr;
   logic [3:0]                   col_wdata;
   logic [7:0] ram_rdata;
   logic [3:0] col_rdata;
   logic [7:0] rom_rdata;

   bmmd_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   bmmd_decode u_decode (
      .mode       (req_chan.mode),
      .address    (req_chan.address),
      .write_data (req_chan.write_data),
      .bank       (bank_ff),
      .acc        (acc)
   );

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign req_ready = !clr.active && (!s1_valid_ff || out_free);
   assign fire      = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   always_comb begin
      ram_we    = fire && acc.ram_we;
      ram_waddr = acc.ram_addr;
      ram_wdata = acc.ram_wdata;
      col_we    = fire && acc.col_we;
      col_waddr = acc.col_addr;
      col_wdata = acc.col_wdata;
      if (clr.active) begin
         ram_we    = 1'b1;
         ram_waddr = clr.addr;
         ram_wdata = clr.wdata;
         col_we    = 1'b1;
         col_waddr = clr.addr[bmmd_pkg::ColorAw-1:0];
         col_wdata = 4'h0;
      end
   end

   bmmd_ram #(.Width(8), .Depth(bmmd_pkg::RamDepth)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (fire && acc.ram_re),
      .raddr (acc.ram_addr),
      .rdata (ram_rdata)
   );

   bmmd_ram #(.Width(4), .Depth(bmmd_pkg::ColorDepth)) u_color (
      .clock (clock),
      .we    (col_we),
      .waddr (col_waddr),
      .wdata (col_wdata),
      .re    (fire && acc.col_re),
      .raddr (acc.col_addr),
      .rdata (col_rdata)
   );

   bmmd_ram #(.Width(8), .Depth(bmmd_pkg::RomDepth)) u_rom (
      .clock (clock),
      .we    (fire && acc.rom_we),
      .waddr (acc.rom_addr),
      .wdata (acc.rom_wdata),
      .re    (fire && acc.rom_re),
      .raddr (acc.rom_addr),
      .rdata (rom_rdata)
   );

   always_comb begin
      bank_in = bank_ff;
      if (fire && acc.bank_we) begin
         bank_in = acc.bank_wdata;
      end
      s1_valid_in = s1_valid_ff;
      s1_sel_in   = s1_sel_ff;
      if (fire) begin
         s1_valid_in = 1'b1;
         s1_sel_in   = acc.sel;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         case (s1_sel_ff)
            bmmd_pkg::SEL_RAM:   out_data_in = ram_rdata;
            bmmd_pkg::SEL_ROM:   out_data_in = rom_rdata;
            bmmd_pkg::SEL_COLOR: out_data_in = bmmd_pkg::ColorSet | {4'h0, col_rdata};
            default:             out_data_in = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= bmmd_pkg::BankReset;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_sel_ff   <= s1_sel_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_data_ff;

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr.active |-> !fire)
      else $error("request accepted during the clearing pass");

   a_one_store_written: assert property (@(posedge clock) disable iff (reset)
      fire |-> $onehot0({acc.ram_we, acc.col_we, acc.rom_we}))
      else $error("one request writes more than one store");

   a_bank_follows_location1: assert property (@(posedge clock) disable iff (reset)
      (fire && acc.bank_we) |-> (acc.ram_we && req_chan.address == bmmd_pkg::BankLoc))
      else $error("bank bits change without a RAM write to location 1");

   a_stalled_read_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_sel_ff)))
      else $error("pending read data lost while the response is stalled");

   a_read_only_selects: assert property (@(posedge clock) disable iff (reset)
      (fire && req_chan.mode != bmmd_pkg::MODE_READ) |-> (acc.sel == bmmd_pkg::SEL_ZERO))
      else $error("non-read request selects a memory for its response");

endmodule
